@@ hdl/mtep_pkg.sv @@
package mtep_pkg;

    // Field widths fixed by the stream format
    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int CHAN_W      = 4;
    localparam int DELTA_W     = 28;
    localparam int NOTE_W      = 8;
    localparam int TOTAL_W     = 32;
    localparam int SKIP_W      = 9;
    localparam int RES_DATA_W  = CHAN_W + DELTA_W + NOTE_W + TOTAL_W + TOTAL_W;
    localparam int TDATA_W     = ((RES_DATA_W + 7) / 8) * 8;

    // Default width of the note-on / note-off counters
    localparam int COUNT_BITS_DEF = 32;

    // Result kinds, carried on tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE_OFF = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_END      = 2'd2,
        KIND_ERROR    = 2'd3
    } t_kind;

    // Parser phase
    typedef enum logic [3:0] {
        PH_DELTA     = 4'd0,
        PH_STATUS    = 4'd1,
        PH_NOTE_KEY  = 4'd2,
        PH_NOTE_VEL  = 4'd3,
        PH_SKIP      = 4'd4,
        PH_META_TYPE = 4'd5,
        PH_META_LEN  = 4'd6,
        PH_END_LEN   = 4'd7
    } t_phase;

    // Status nibbles and meta codes
    localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
    localparam logic [3:0] ST_NOTE_ON   = 4'h9;
    localparam logic [3:0] ST_POLY_PRES = 4'hA;
    localparam logic [3:0] ST_CTRL_CHG  = 4'hB;
    localparam logic [3:0] ST_PROG_CHG  = 4'hC;
    localparam logic [3:0] ST_CHAN_PRES = 4'hD;
    localparam logic [3:0] ST_PITCH     = 4'hE;
    localparam logic [7:0] ST_META      = 8'hFF;

    localparam logic [7:0] META_CHAN_PFX = 8'h20;
    localparam logic [7:0] META_EOT      = 8'h2F;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [7:0] META_SMPTE    = 8'h54;
    localparam logic [7:0] META_TIME_SIG = 8'h58;
    localparam logic [7:0] META_KEY_SIG  = 8'h59;

    localparam logic [CHAN_W-1:0] EOT_CHANNEL = 4'hF;

    // One result item
    typedef struct packed {
        logic [TOTAL_W-1:0] note_off_total;
        logic [TOTAL_W-1:0] note_on_total;
        logic [NOTE_W-1:0]  note_number;
        logic [DELTA_W-1:0] delta_time;
        logic [CHAN_W-1:0]  channel;
        t_kind              kind;
    } t_result;

endpackage

@@ hdl/mtep_parser.sv @@
module mtep_parser
    import mtep_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    t_phase                  r_phase, n_phase;
    logic [DELTA_W-1:0]      r_delta, n_delta;
    logic [SKIP_W-1:0]       r_skip, n_skip;
    logic                    r_is_on, n_is_on;
    logic [CHAN_W-1:0]       r_chan, n_chan;
    logic [NOTE_W-1:0]       r_note, n_note;
    logic [COUNT_BITS-1:0]   r_on_cnt, n_on_cnt;
    logic [COUNT_BITS-1:0]   r_off_cnt, n_off_cnt;
    logic [TOTAL_W-1:0]      on_total, off_total;

    logic [3:0]              hi_nib;
    logic [DELTA_W-1:0]      delta_shift;
    logic [SKIP_W-1:0]       skip_dec;
    logic [SKIP_W-1:0]       meta_len;
    logic                    meta_fixed;

    assign hi_nib      = i_byte[7:4];
    assign delta_shift = {r_delta[DELTA_W-8:0], i_byte[6:0]};
    assign skip_dec    = (r_skip != '0) ? r_skip - SKIP_W'(1) : r_skip;

    // Counter view on the result: low bits, or zero-extended when narrow
    generate
        if (COUNT_BITS >= TOTAL_W) begin : g_wide
            assign on_total  = r_on_cnt[TOTAL_W-1:0];
            assign off_total = r_off_cnt[TOTAL_W-1:0];
        end else begin : g_narrow
            assign on_total  = {{(TOTAL_W-COUNT_BITS){1'b0}}, r_on_cnt};
            assign off_total = {{(TOTAL_W-COUNT_BITS){1'b0}}, r_off_cnt};
        end
    endgenerate

    // Fixed skip lengths of the known meta types
    always_comb begin
        meta_fixed = 1'b1;
        meta_len   = '0;
        unique case (i_byte)
            META_CHAN_PFX: meta_len = SKIP_W'(2);
            META_TEMPO:    meta_len = SKIP_W'(4);
            META_SMPTE:    meta_len = SKIP_W'(6);
            META_TIME_SIG: meta_len = SKIP_W'(5);
            META_KEY_SIG:  meta_len = SKIP_W'(3);
            default:       meta_fixed = 1'b0;
        endcase
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_byte_valid) begin
            unique case (r_phase)
                PH_STATUS: begin
                    if (hi_nib == ST_NOTE_OFF || hi_nib == ST_NOTE_ON) begin
                        n_phase = PH_NOTE_KEY;
                    end else if (hi_nib == ST_POLY_PRES || hi_nib == ST_CTRL_CHG ||
                                 hi_nib == ST_PITCH || hi_nib == ST_PROG_CHG ||
                                 hi_nib == ST_CHAN_PRES) begin
                        n_phase = PH_SKIP;
                    end else if (i_byte == ST_META) begin
                        n_phase = PH_META_TYPE;
                    end else begin
                        n_phase = i_byte[7] ? PH_DELTA : PH_STATUS;
                    end
                end
                PH_NOTE_KEY: n_phase = PH_NOTE_VEL;
                PH_NOTE_VEL: n_phase = PH_DELTA;
                PH_SKIP:     n_phase = (skip_dec == '0) ? PH_DELTA : PH_SKIP;
                PH_META_TYPE: begin
                    if (i_byte == META_EOT) begin
                        n_phase = PH_END_LEN;
                    end else if (meta_fixed) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_phase = PH_META_LEN;
                    end
                end
                PH_META_LEN: n_phase = (i_byte == '0) ? PH_DELTA : PH_SKIP;
                PH_END_LEN:  n_phase = PH_DELTA;
                default:     n_phase = i_byte[7] ? PH_DELTA : PH_STATUS;
            endcase
        end
    end

    // Datapath registers and result
    always_comb begin
        n_delta     = r_delta;
        n_skip      = r_skip;
        n_is_on     = r_is_on;
        n_chan      = r_chan;
        n_note      = r_note;
        n_on_cnt    = r_on_cnt;
        n_off_cnt   = r_off_cnt;
        o_res_valid = 1'b0;
        o_res.kind           = KIND_NOTE_OFF;
        o_res.channel        = r_chan;
        o_res.delta_time     = r_delta;
        o_res.note_number    = '0;
        o_res.note_on_total  = on_total;
        o_res.note_off_total = off_total;
        if (i_byte_valid) begin
            unique case (r_phase)
                PH_STATUS: begin
                    n_chan = i_byte[3:0];
                    if (hi_nib == ST_NOTE_ON) begin
                        n_is_on  = 1'b1;
                        n_on_cnt = r_on_cnt + COUNT_BITS'(1);
                    end else if (hi_nib == ST_NOTE_OFF) begin
                        n_is_on   = 1'b0;
                        n_off_cnt = r_off_cnt + COUNT_BITS'(1);
                    end else if (hi_nib == ST_POLY_PRES || hi_nib == ST_CTRL_CHG ||
                                 hi_nib == ST_PITCH) begin
                        n_skip = SKIP_W'(2);
                    end else if (hi_nib == ST_PROG_CHG || hi_nib == ST_CHAN_PRES) begin
                        n_skip = SKIP_W'(1);
                    end else if (i_byte != ST_META) begin
                        // unknown status: report, then the byte opens a new delta
                        o_res_valid   = 1'b1;
                        o_res.kind    = KIND_ERROR;
                        o_res.channel = i_byte[3:0];
                        n_delta       = {{(DELTA_W-7){1'b0}}, i_byte[6:0]};
                    end
                end
                PH_NOTE_KEY: n_note = i_byte;
                PH_NOTE_VEL: begin
                    o_res_valid       = 1'b1;
                    o_res.kind        = (r_is_on && i_byte != '0) ? KIND_NOTE_ON
                                                                  : KIND_NOTE_OFF;
                    o_res.note_number = r_note;
                    n_delta           = '0;
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_delta = '0;
                    end
                end
                PH_META_TYPE: begin
                    if (meta_fixed) begin
                        n_skip = meta_len;
                    end
                end
                PH_META_LEN: begin
                    n_skip = {1'b0, i_byte};
                    if (i_byte == '0) begin
                        n_delta = '0;
                    end
                end
                PH_END_LEN: begin
                    o_res_valid   = 1'b1;
                    o_res.kind    = KIND_END;
                    o_res.channel = EOT_CHANNEL;
                    n_delta       = '0;
                end
                default: n_delta = delta_shift;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_DELTA;
            r_delta   <= '0;
            r_skip    <= '0;
            r_is_on   <= 1'b0;
            r_chan    <= '0;
            r_note    <= '0;
            r_on_cnt  <= '0;
            r_off_cnt <= '0;
        end else begin
            r_phase   <= n_phase;
            r_delta   <= n_delta;
            r_skip    <= n_skip;
            r_is_on   <= n_is_on;
            r_chan    <= n_chan;
            r_note    <= n_note;
            r_on_cnt  <= n_on_cnt;
            r_off_cnt <= n_off_cnt;
        end
    end

endmodule

@@ hdl/midi_track_event_parser_core.sv @@
// MIDI track event parser.
// Input stream (s_axis_*): one byte of a track body per item, in tdata[7:0].
// Output stream (m_axis_*): one item per note off, note on, end of track or
// unknown status byte; the kind travels on tuser, the rest on tdata.
// Each input byte is decoded in the cycle it is accepted; a byte that completes
// an event has its result item registered in the output register, or in the
// skid entry while m_axis stalls. Throughput is one byte per cycle while the
// receiver keeps up; the parser state and counters update once per accepted
// byte. A result register with a one-entry skid stage sits on the output, so
// input keeps flowing while a result waits; s_axis_tready falls only when both
// hold a result, and rises again the cycle after the receiver takes one.
// Reset (synchronous, active low) returns the parser to waiting for a delta
// time byte, clears both event counters and empties the output stages.
module midi_track_event_parser_core
    import mtep_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [3:0] channel, [31:4] delta_time, [39:32] note_number,
    // [71:40] note_on_total, [103:72] note_off_total
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [KIND_W-1:0]  m_axis_tuser    // [1:0] kind
);

    logic    in_acc;
    logic    res_valid;
    t_result res;

    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    logic    out_free;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    mtep_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (in_acc),
        .i_byte       (s_axis_tdata),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Output register plus skid entry
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = in_acc && res_valid;
            end
        end else if (in_acc && res_valid) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = TDATA_W'({r_out.note_off_total, r_out.note_on_total,
                                     r_out.note_number, r_out.delta_time,
                                     r_out.channel});

endmodule

@@ hdl/mtep_checker.sv @@
module mtep_checker
    import mtep_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [BYTE_W-1:0]  s_axis_tdata,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]  m_axis_tuser
);

    // Output stages are empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result item present after reset");

    // A stalled result item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result item changed");

    // Input stalls only when a result is waiting at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with output empty");

    // End of track reports channel 15 and no note
    a_eot_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_END |->
            m_axis_tdata[3:0] == EOT_CHANNEL && m_axis_tdata[39:32] == '0)
        else $error("end of track fields wrong");

    // Unknown status carries no note number
    a_err_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tdata[39:32] == '0)
        else $error("error item carries a note number");

endmodule

bind midi_track_event_parser_core mtep_checker u_mtep_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
